### rtl/lcfs_pkg.sv
// Shared types, constants and the color table of the LED color fade sequencer.
`default_nettype none

package lcfs_pkg;

    // Defaults and limits
    localparam int          TIME_WIDTH_DEF = 32;
    localparam int          CFG_IDX_W      = 1;
    localparam int          CFG_DATA_W     = 16;
    localparam logic [15:0] DEBOUNCE_RST   = 16'd200;
    localparam logic [15:0] LONG_PRESS_RST = 16'd5000;
    localparam logic [7:0]  LEVEL_MAX      = 8'd255;
    localparam logic [3:0]  COLOR_OFF      = 4'd8;
    localparam logic [3:0]  COLOR_FIRST    = 4'd0;
    localparam logic [3:0]  NEXT_RST       = 4'd1;
    localparam logic [3:0]  NUM_COLORS     = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'd1;

    // Input item: one tick
    typedef struct packed {
        logic        button_down;
        logic [31:0] now_ms;
    } in_item_t;

    // Result item: scaled channels plus current level and color
    typedef struct packed {
        logic [7:0] chan_first;
        logic [7:0] chan_second;
        logic [7:0] chan_third;
        logic [7:0] level_out;
        logic [3:0] color_out;
    } out_item_t;

    // Post-tick view of the fade state, handed to the scaler
    typedef struct packed {
        logic [7:0] level;
        logic [3:0] color;
    } fade_view_t;

    // Color table: first byte in [23:16], second in [15:8], third in [7:0].
    // Off and anything above it read as black.
    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = {8'd255, 8'd0,   8'd0};
            4'd1:    rgb = {8'd0,   8'd255, 8'd0};
            4'd2:    rgb = {8'd0,   8'd0,   8'd255};
            4'd3:    rgb = {8'd255, 8'd255, 8'd0};
            4'd4:    rgb = {8'd255, 8'd0,   8'd255};
            4'd5:    rgb = {8'd0,   8'd255, 8'd255};
            4'd6:    rgb = {8'd0,   8'd191, 8'd205};
            4'd7:    rgb = {8'd50,  8'd138, 8'd51};
            default: rgb = 24'd0;
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

### rtl/lcfs_fade.sv
// Button debounce, press timing and brightness/color fade state machine.
`default_nettype none

module lcfs_fade #(
    parameter int TIME_WIDTH = lcfs_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   button_down,
    input  wire logic [TIME_WIDTH-1:0]  now,
    input  wire logic [15:0]            debounce_ms,
    input  wire logic [15:0]            long_press_ms,
    output lcfs_pkg::fade_view_t        view
);
    import lcfs_pkg::*;

    logic                  held_reg,       held_next;
    logic [TIME_WIDTH-1:0] press_start_reg, press_start_next;
    logic [TIME_WIDTH-1:0] last_accept_reg, last_accept_next;
    logic [3:0]            color_reg,      color_next;
    logic [3:0]            next_idx_reg,   next_idx_next;
    logic [7:0]            level_reg,      level_next;
    logic                  rising_reg,     rising_next;
    logic                  trans_reg,      trans_next;

    logic [TIME_WIDTH-1:0] since_accept;
    logic [TIME_WIDTH-1:0] press_dur;
    logic [3:0]            color_inc;

    // Time differences wrap at the timer width
    assign since_accept = now - last_accept_reg;
    assign press_dur    = now - press_start_reg;
    assign color_inc    = color_reg + 4'd1;

    // Next state for one tick
    always_comb
    begin
        held_next        = held_reg;
        press_start_next = press_start_reg;
        last_accept_next = last_accept_reg;
        color_next       = color_reg;
        next_idx_next    = next_idx_reg;
        level_next       = level_reg;
        rising_next      = rising_reg;
        trans_next       = trans_reg;

        // Debounced press start
        if (button_down && !held_reg &&
            since_accept > TIME_WIDTH'(debounce_ms))
        begin
            held_next        = 1'b1;
            press_start_next = now;
            last_accept_next = now;
        end

        // Release: long press turns off, short press starts a color change
        if (!button_down && held_reg)
        begin
            held_next   = 1'b0;
            rising_next = 1'b0;
            if (press_dur >= TIME_WIDTH'(long_press_ms))
            begin
                color_next = COLOR_OFF;
                trans_next = 1'b0;
            end
            else
            begin
                next_idx_next = {1'b0, color_inc[2:0]};
                trans_next    = 1'b1;
            end
        end

        // Brightness step
        if (trans_next)
        begin
            if (!rising_next)
            begin
                if (level_reg != 8'd0)
                begin
                    level_next = level_reg - 8'd1;
                end
                else
                begin
                    color_next  = next_idx_next;
                    rising_next = 1'b1;
                end
            end
            else
            begin
                if (level_reg != LEVEL_MAX)
                begin
                    level_next = level_reg + 8'd1;
                end
                else
                begin
                    trans_next = 1'b0;
                end
            end
        end
        else
        begin
            if (rising_next)
            begin
                if (level_reg != LEVEL_MAX)
                begin
                    level_next = level_reg + 8'd1;
                end
                else
                begin
                    rising_next = 1'b0;
                end
            end
            else
            begin
                if (level_reg != 8'd0)
                begin
                    level_next = level_reg - 8'd1;
                end
                else
                begin
                    rising_next = 1'b1;
                end
            end
        end
    end

    // State registers, advanced once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= 1'b0;
            press_start_reg <= '0;
            last_accept_reg <= '0;
            color_reg       <= COLOR_FIRST;
            next_idx_reg    <= NEXT_RST;
            level_reg       <= 8'd0;
            rising_reg      <= 1'b1;
            trans_reg       <= 1'b0;
        end
        else if (en)
        begin
            held_reg        <= held_next;
            press_start_reg <= press_start_next;
            last_accept_reg <= last_accept_next;
            color_reg       <= color_next;
            next_idx_reg    <= next_idx_next;
            level_reg       <= level_next;
            rising_reg      <= rising_next;
            trans_reg       <= trans_next;
        end
    end

    // Values after this tick
    assign view.level = level_next;
    assign view.color = color_next;

    // Checks
    a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
        color_reg <= COLOR_OFF)
        else $error("color index beyond off");

    a_next_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_idx_reg < NUM_COLORS)
        else $error("pending color index out of range");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(level_reg) && $stable(color_reg) && $stable(held_reg)))
        else $error("fade state moved without a tick");

    a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> (level_reg == $past(level_reg) ||
                level_reg == $past(level_reg) + 8'd1 ||
                level_reg == $past(level_reg) - 8'd1))
        else $error("brightness moved by more than one step");

endmodule

`default_nettype wire

### rtl/lcfs_scale.sv
// Color table lookup and brightness scaling of the three channels (floor of x/255).
`default_nettype none

module lcfs_scale (
    input  wire lcfs_pkg::fade_view_t view,
    output logic [7:0]                chan_first,
    output logic [7:0]                chan_second,
    output logic [7:0]                chan_third
);
    import lcfs_pkg::*;

    logic [23:0] rgb;
    logic [15:0] prod [3];
    logic [16:0] sum  [3];
    logic [7:0]  chan [3];

    assign rgb = palette_rgb(view.color);

    // x/255 for x up to 255*255 is (x + 1 + (x >> 8)) >> 8
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod[i] = 16'(rgb[16 - 8*i +: 8]) * 16'(view.level);
            sum[i]  = 17'(prod[i]) + 17'd1 + 17'(prod[i][15:8]);
            chan[i] = sum[i][15:8];
        end
    end

    assign chan_first  = chan[0];
    assign chan_second = chan[1];
    assign chan_third  = chan[2];

endmodule

`default_nettype wire

### rtl/led_color_fade_sequencer.sv
// Top level of the LED color fade sequencer: handshakes, config registers, pipeline.
//
// Usage:
//   Each input item is one tick: button level and a millisecond timestamp.
//   Each tick yields exactly one result item: the current color scaled by
//   brightness on three channels, plus the brightness level and color index.
//   Both channels are valid/ready; an item moves when valid and ready are high.
//   An accepted item lands in the input register; its result is loaded into
//   the output register once that is free or being taken, and is offered
//   from then on. Throughput is one item per cycle while out_ready stays high,
//   set by the single update-and-scale stage between the two registers.
//   When the receiver stalls, the result holds and the input register keeps
//   one more item; input ready drops only when both are full.
//   Config: cfg_we writes cfg_data to register cfg_index (0 debounce,
//   1 long press) at once; write only while no item is in flight.
//   Reset (asynchronous, active low) empties the pipeline, loads the default
//   debounce and long-press times and returns the fade state to color 0,
//   brightness 0, rising, no press held.
`default_nettype none

module led_color_fade_sequencer #(
    parameter int TIME_WIDTH = lcfs_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire lcfs_pkg::in_item_t               in_item,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output lcfs_pkg::out_item_t                   out_item,
    input  wire logic                             cfg_we,
    input  wire logic [lcfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lcfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lcfs_pkg::*;

    logic                  a_valid_reg;
    in_item_t              a_item_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg, out_item_next;
    logic [15:0]           debounce_reg;
    logic [15:0]           long_press_reg;
    logic                  tick;
    logic [TIME_WIDTH-1:0] now;
    fade_view_t            view;

    // Pipeline control
    assign tick     = a_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || tick;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                CFG_LONG_PRESS: long_press_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_item_reg <= in_item;
        end
    end

    // Timestamp at the timer width
    assign now = TIME_WIDTH'(a_item_reg.now_ms);

    lcfs_fade #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fade (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (tick),
        .button_down   (a_item_reg.button_down),
        .now           (now),
        .debounce_ms   (debounce_reg),
        .long_press_ms (long_press_reg),
        .view          (view)
    );

    lcfs_scale u_scale (
        .view        (view),
        .chan_first  (out_item_next.chan_first),
        .chan_second (out_item_next.chan_second),
        .chan_third  (out_item_next.chan_third)
    );

    assign out_item_next.level_out = view.level;
    assign out_item_next.color_out = view.color;

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire
